@@ design/cbcm_pkg.sv @@
// Shared constants, types and step functions for the circle-box contact pipeline.
package cbcm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int SIZE_W    = 31;
	localparam int NORM_W    = 18;
	localparam int ROOT_BITS = 34;
	localparam int OP_W      = 2 * ROOT_BITS;
	localparam int REM_W     = ROOT_BITS + 3;
	localparam int QUO_BITS  = FRAC_BITS + 1;
	localparam int DREM_W    = ROOT_BITS + 1;
	localparam int PROD_W    = QUO_BITS + SIZE_W;

	// payload carried alongside the arithmetic
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [SIZE_W-1:0]         r;
		logic [COORD_W-1:0]        nx;
		logic [COORD_W-1:0]        ny;
		logic [COORD_W-1:0]        adx;
		logic [COORD_W-1:0]        ady;
		logic                      negx;
		logic                      negy;
	} item_t;

	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [ROOT_BITS-1:0] root;
		logic [OP_W-1:0]      op;
	} sqrt_t;

	typedef struct packed {
		logic [DREM_W-1:0]   rem;
		logic [QUO_BITS-1:0] quo;
		logic [QUO_BITS-1:0] dv;
	} div_t;

	// one root bit: bring down two operand bits and try the next root digit
	function automatic sqrt_t sqrt_step(sqrt_t s);
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] trial;
		logic             ge;
		sqrt_t            o;
		t     = {s.rem[REM_W-3:0], s.op[OP_W-1 -: 2]};
		trial = {1'b0, s.root, 2'b01};
		ge    = (t >= trial);
		o.rem  = ge ? (t - trial) : t;
		o.root = {s.root[ROOT_BITS-2:0], ge};
		o.op   = {s.op[OP_W-3:0], 2'b00};
		return o;
	endfunction

	// one quotient bit of a restoring division
	function automatic div_t div_step(div_t s, logic [ROOT_BITS-1:0] len);
		logic [DREM_W-1:0] t;
		logic [DREM_W-1:0] d;
		logic              ge;
		div_t              o;
		t  = {s.rem[DREM_W-2:0], s.dv[QUO_BITS-1]};
		d  = {1'b0, len};
		ge = (t >= d);
		o.rem = ge ? (t - d) : t;
		o.quo = {s.quo[QUO_BITS-2:0], ge};
		o.dv  = {s.dv[QUO_BITS-2:0], 1'b0};
		return o;
	endfunction

	// start a division of (mag << FRAC_BITS)
	function automatic div_t div_init(logic [COORD_W-1:0] m);
		div_t o;
		o.rem = {{(DREM_W-COORD_W+1){1'b0}}, m[COORD_W-1:1]};
		o.quo = '0;
		o.dv  = {m[0], {FRAC_BITS{1'b0}}};
		return o;
	endfunction

	// saturate a 35-bit signed value to 32 bits
	function automatic logic [COORD_W-1:0] sat32(logic signed [34:0] v);
		logic [COORD_W-1:0] o;
		if (v > 35'sh0_7FFF_FFFF) begin
			o = 32'h7FFF_FFFF;
		end else if (v < -35'sh0_8000_0000) begin
			o = 32'h8000_0000;
		end else begin
			o = v[COORD_W-1:0];
		end
		return o;
	endfunction

endpackage

@@ design/circle_box_contact_manifold.sv @@
// Pipelined circle against axis-aligned rectangle contact manifold.
//
//  channel | direction | handshake           | fields
//  in      | input     | in_valid/in_stall   | circle_x..box_height
//  out     | output    | out_valid/out_stall | contact_a_x..penetration
//
// One item per cycle while the pipe is not held: clamp, two squares, sum, 34 root
// stages (one bit each), 17 divider stages (one bit per axis each), multiply, output.
// The root and divider stages set the depth. arst_n clears the valid bits.
// The whole pipe holds while a result waits and out_stall is high; in_stall
// follows that hold, so nothing is lost or repeated.
module circle_box_contact_manifold
	import cbcm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] circle_x,
	input  logic signed [COORD_W-1:0] circle_y,
	input  logic [SIZE_W-1:0]         circle_radius,
	input  logic signed [COORD_W-1:0] box_x,
	input  logic signed [COORD_W-1:0] box_y,
	input  logic [SIZE_W-1:0]         box_width,
	input  logic [SIZE_W-1:0]         box_height,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] contact_a_x,
	output logic signed [COORD_W-1:0] contact_a_y,
	output logic signed [COORD_W-1:0] contact_b_x,
	output logic signed [COORD_W-1:0] contact_b_y,
	output logic signed [NORM_W-1:0]  normal_x,
	output logic signed [NORM_W-1:0]  normal_y,
	output logic signed [COORD_W-1:0] penetration
);

	logic en;
	assign en       = ~(out_valid & out_stall);
	assign in_stall = ~en;

	// stage 1: clamp
	logic                      v_s1;
	item_t                     it_s1;
	logic signed [COORD_W:0]   lox, hix, loy, hiy, cxe, cye, nxe, nye;
	logic signed [COORD_W+1:0] dxe, dye;

	always_comb begin
		cxe = {circle_x[COORD_W-1], circle_x};
		cye = {circle_y[COORD_W-1], circle_y};
		lox = {box_x[COORD_W-1], box_x};
		loy = {box_y[COORD_W-1], box_y};
		hix = lox + $signed({2'b00, box_width});
		hiy = loy + $signed({2'b00, box_height});
		if (cxe < lox) begin
			nxe = lox;
		end else if (cxe > hix) begin
			nxe = hix;
		end else begin
			nxe = cxe;
		end
		if (cye < loy) begin
			nye = loy;
		end else if (cye > hiy) begin
			nye = hiy;
		end else begin
			nye = cye;
		end
		dxe = {nxe[COORD_W], nxe} - {cxe[COORD_W], cxe};
		dye = {nye[COORD_W], nye} - {cye[COORD_W], cye};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1.cx   <= circle_x;
			it_s1.cy   <= circle_y;
			it_s1.r    <= circle_radius;
			it_s1.nx   <= nxe[COORD_W-1:0];
			it_s1.ny   <= nye[COORD_W-1:0];
			it_s1.negx <= dxe[COORD_W+1];
			it_s1.negy <= dye[COORD_W+1];
			it_s1.adx  <= dxe[COORD_W+1] ? COORD_W'(-dxe) : dxe[COORD_W-1:0];
			it_s1.ady  <= dye[COORD_W+1] ? COORD_W'(-dye) : dye[COORD_W-1:0];
		end
	end

	// stage 2: squares
	logic                     v_s2;
	item_t                    it_s2;
	logic [2*COORD_W-1:0]     sqx_s2, sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2  <= it_s1;
			sqx_s2 <= it_s1.adx * it_s1.adx;
			sqy_s2 <= it_s1.ady * it_s1.ady;
		end
	end

	// stage 3: squared length, start of the root
	logic  v_sq [0:ROOT_BITS];
	item_t it_sq [0:ROOT_BITS];
	sqrt_t st_sq [0:ROOT_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq[0] <= 1'b0;
		end else if (en) begin
			v_sq[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_sq[0]      <= it_s2;
			st_sq[0].rem  <= '0;
			st_sq[0].root <= '0;
			st_sq[0].op   <= OP_W'({1'b0, sqx_s2} + {1'b0, sqy_s2});
		end
	end

	// root stages, one bit each
	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq[k+1] <= 1'b0;
			end else if (en) begin
				v_sq[k+1] <= v_sq[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_sq[k+1] <= it_sq[k];
				st_sq[k+1] <= sqrt_step(st_sq[k]);
			end
		end
	end

	// divider stages, one quotient bit per axis each
	logic                 v_dv  [0:QUO_BITS];
	item_t                it_dv [0:QUO_BITS];
	logic [ROOT_BITS-1:0] len_dv [0:QUO_BITS];
	div_t                 dx_dv [0:QUO_BITS];
	div_t                 dy_dv [0:QUO_BITS];

	always_comb begin
		v_dv[0]   = v_sq[ROOT_BITS];
		it_dv[0]  = it_sq[ROOT_BITS];
		len_dv[0] = st_sq[ROOT_BITS].root;
		dx_dv[0]  = div_init(it_sq[ROOT_BITS].adx);
		dy_dv[0]  = div_init(it_sq[ROOT_BITS].ady);
	end

	for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dv[j+1] <= 1'b0;
			end else if (en) begin
				v_dv[j+1] <= v_dv[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_dv[j+1]  <= it_dv[j];
				len_dv[j+1] <= len_dv[j];
				dx_dv[j+1]  <= div_step(dx_dv[j], len_dv[j]);
				dy_dv[j+1]  <= div_step(dy_dv[j], len_dv[j]);
			end
		end
	end

	// multiply stage: scale the unit direction by the radius
	logic                 lz;
	logic [QUO_BITS-1:0]  umx, umy;
	logic                 v_s4;
	item_t                it_s4;
	logic [ROOT_BITS-1:0] len_s4;
	logic                 lz_s4;
	logic [QUO_BITS-1:0]  umx_s4, umy_s4;
	logic [PROD_W-1:0]    px_s4, py_s4;

	always_comb begin
		lz  = (len_dv[QUO_BITS] == '0);
		umx = lz ? '0 : dx_dv[QUO_BITS].quo;
		umy = lz ? QUO_BITS'(1 << FRAC_BITS) : dy_dv[QUO_BITS].quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_dv[QUO_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4  <= it_dv[QUO_BITS];
			len_s4 <= len_dv[QUO_BITS];
			lz_s4  <= lz;
			umx_s4 <= umx;
			umy_s4 <= umy;
			px_s4  <= umx * it_dv[QUO_BITS].r;
			py_s4  <= umy * it_dv[QUO_BITS].r;
		end
	end

	// output stage: add offsets, saturate, form normal and depth
	logic                      sx, sy;
	logic [COORD_W-1:0]        ox, oy;
	logic signed [34:0]        ax, ay, dep;

	always_comb begin
		sx  = it_s4.negx & ~lz_s4;
		sy  = it_s4.negy & ~lz_s4;
		ox  = px_s4[PROD_W-1 -: COORD_W];
		oy  = py_s4[PROD_W-1 -: COORD_W];
		ax  = 35'(it_s4.cx) + (sx ? -$signed({3'b000, ox}) : $signed({3'b000, ox}));
		ay  = 35'(it_s4.cy) + (sy ? -$signed({3'b000, oy}) : $signed({3'b000, oy}));
		dep = lz_s4 ? '0 : ($signed({4'b0000, it_s4.r}) - $signed({1'b0, len_s4}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			contact_a_x <= sat32(ax);
			contact_a_y <= sat32(ay);
			contact_b_x <= it_s4.nx;
			contact_b_y <= it_s4.ny;
			normal_x    <= sx ? NORM_W'(umx_s4) : -NORM_W'(umx_s4);
			normal_y    <= sy ? NORM_W'(umy_s4) : -NORM_W'(umy_s4);
			penetration <= sat32(dep);
		end
	end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the circle against rectangle contact manifold pipeline.
`timescale 1ns / 1ps

module testbench;
	import cbcm_pkg::*;

	localparam int FB          = 16;
	localparam int LATENCY     = 56;
	localparam int RANDOM_ITEMS = 400;
	localparam int WATCHDOG    = 20000;
	localparam int HOLD_CYCLES = 300;
	localparam int LAST_PHASE  = 2;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FB;
	localparam logic signed [63:0] MAX32 = 64'sd2147483647;
	localparam logic signed [63:0] MIN32 = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] cx, cy, bx, by;
		logic [30:0]        r, bw, bh;
	} pair_t;

	typedef struct {
		logic signed [31:0] ax, ay, bx, by, depth;
		logic signed [17:0] nx, ny;
	} manifold_t;

	typedef struct {
		pair_t     p;
		bit        typed;
		manifold_t m;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] circle_x = '0, circle_y = '0, box_x = '0, box_y = '0;
	logic [30:0] circle_radius = '0, box_width = '0, box_height = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic signed [31:0] contact_a_x, contact_a_y, contact_b_x, contact_b_y, penetration;
	logic signed [17:0] normal_x, normal_y;

	manifold_t expected_q[$];
	int  errors = 0;
	int  phase = 0;
	int  idle_cycles = 0;
	bit  hold_done = 1'b0;
	bit  sending_done = 1'b0;

	circle_box_contact_manifold uut (.*);

	// clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// floor square root of a value below 2^66
	function automatic logic [63:0] floor_sqrt(logic [65:0] v);
		logic [63:0]  root;
		logic [63:0]  t;
		logic [131:0] sq;
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			t = root | (64'd1 << b);
			sq = t * t;
			if (sq <= v) root = t;
		end
		return root;
	endfunction

	function automatic logic signed [63:0] saturate(logic signed [63:0] v);
		if (v > MAX32) return MAX32;
		if (v < MIN32) return MIN32;
		return v;
	endfunction

	// compute the contact manifold for one circle/box pair
	function automatic manifold_t contact_of(pair_t p);
		logic signed [63:0] near_x, near_y, dx, dy, ux, uy, depth, far;
		logic [63:0]        adx, ady, len, mx, my;
		logic [65:0]        sum;
		manifold_t          m;
		far = 64'(p.bx) + 64'(p.bw);
		near_x = (64'(p.cx) < 64'(p.bx)) ? 64'(p.bx) : (64'(p.cx) > far) ? far : 64'(p.cx);
		far = 64'(p.by) + 64'(p.bh);
		near_y = (64'(p.cy) < 64'(p.by)) ? 64'(p.by) : (64'(p.cy) > far) ? far : 64'(p.cy);
		dx = near_x - 64'(p.cx);
		dy = near_y - 64'(p.cy);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		sum = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
		len = floor_sqrt(sum);
		if (len == 0) begin
			ux = 0;
			uy = ONE;
			depth = 0;
		end else begin
			ux = (adx << FB) / len;
			uy = (ady << FB) / len;
			if (dx < 0) ux = -ux;
			if (dy < 0) uy = -uy;
			depth = saturate(64'(p.r) - $signed(len));
		end
		mx = ((ux < 0 ? -ux : ux) * 64'(p.r)) >> FB;
		my = ((uy < 0 ? -uy : uy) * 64'(p.r)) >> FB;
		m.ax = saturate(64'(p.cx) + (ux < 0 ? -$signed(mx) : $signed(mx)));
		m.ay = saturate(64'(p.cy) + (uy < 0 ? -$signed(my) : $signed(my)));
		m.bx = near_x[31:0];
		m.by = near_y[31:0];
		m.nx = 18'(-ux);
		m.ny = 18'(-uy);
		m.depth = depth[31:0];
		return m;
	endfunction

	function automatic pair_t mk(logic signed [31:0] cx, logic signed [31:0] cy,
			logic [30:0] r, logic signed [31:0] bx, logic signed [31:0] by,
			logic [30:0] bw, logic [30:0] bh);
		pair_t p;
		p.cx = cx; p.cy = cy; p.r = r; p.bx = bx; p.by = by; p.bw = bw; p.bh = bh;
		return p;
	endfunction

	function automatic manifold_t mf(logic signed [31:0] ax, logic signed [31:0] ay,
			logic signed [31:0] bx, logic signed [31:0] by, logic signed [17:0] nx,
			logic signed [17:0] ny, logic signed [31:0] depth);
		manifold_t m;
		m.ax = ax; m.ay = ay; m.bx = bx; m.by = by; m.nx = nx; m.ny = ny; m.depth = depth;
		return m;
	endfunction

	// random pair, mostly near contact so the depth changes sign often
	function automatic pair_t random_pair();
		pair_t p;
		int    kind;
		kind = $urandom_range(0, 9);
		p.cx = $urandom; p.cy = $urandom; p.bx = $urandom; p.by = $urandom;
		p.r = $urandom; p.bw = $urandom; p.bh = $urandom;
		if (kind < 6) begin
			p.bx = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			p.by = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			p.bw = $urandom_range(0, 32'h003F_FFFF);
			p.bh = $urandom_range(0, 32'h003F_FFFF);
			p.cx = p.bx + $signed($urandom_range(0, 32'h00BF_FFFF)) - 32'sh0040_0000;
			p.cy = p.by + $signed($urandom_range(0, 32'h00BF_FFFF)) - 32'sh0040_0000;
			p.r = $urandom_range(0, 32'h0040_0000);
		end else if (kind < 8) begin
			p.r = p.r >> $urandom_range(0, 30);
			p.bw = p.bw >> $urandom_range(0, 30);
			p.bh = p.bh >> $urandom_range(0, 30);
		end
		return p;
	endfunction

	// send one pair, wait for its transfer and queue its expectation
	task automatic send_pair(pair_t p, bit typed, manifold_t m);
		while (phase < LAST_PHASE && $urandom_range(0, 99) < (phase == 0 ? 27 : 51)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		circle_x <= p.cx; circle_y <= p.cy; circle_radius <= p.r;
		box_x <= p.bx; box_y <= p.by; box_width <= p.bw; box_height <= p.bh;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_q.push_back(typed ? m : contact_of(p));
	endtask

	// stimulus
	initial begin
		row_t rows[$];
		manifold_t none;
		row_t r;
		none = '{default: 0};
		r.typed = 1'b1;
		r.p = mk(0, 0, 0, 0, 0, 0, 0);
		r.m = mf(0, 0, 0, 0, 0, -18'sd65536, 0); rows.push_back(r);
		r.p = mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0,
			32'h0002_0000, 32'h0002_0000);
		r.m = mf(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
			0, -18'sd65536, 0); rows.push_back(r);
		// circle to the left of box, axis aligned
		r.p = mk(0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0,
			32'h0001_0000, 32'h0002_0000);
		r.m = mf(32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000,
			-18'sd65536, 0, -32'sh0001_0000); rows.push_back(r);
		r.typed = 1'b0;
		r.m = none;
		r.p = mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 0, 0); rows.push_back(r);
		r.p = mk(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF); rows.push_back(r);
		r.p = mk(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 0, 0); rows.push_back(r);
		r.p = mk(32'sh7FFF_FFFF, 0, 31'h7FFF_FFFF, 32'sh8000_0000, 0,
			31'h7FFF_FFFF, 0); rows.push_back(r);
		r.p = mk(32'sh0010_0000, 32'sh0010_0000, 31'h0000_0001, 0, 0,
			31'h0001_0000, 31'h0001_0000); rows.push_back(r);
		r.p = mk(-32'sh0005_0000, 32'sh0005_0000, 31'h0010_0000, 0, 0,
			31'h0001_0000, 31'h0001_0000); rows.push_back(r);
		r.p = mk(32'sh0003_8000, -32'sh0002_4000, 31'h0000_8000, 0, 0,
			31'h0001_0000, 31'h0001_0000); rows.push_back(r);
		r.p = mk(1, 1, 31'h7FFF_FFFF, 0, 0, 0, 0); rows.push_back(r);
		r.p = mk(-1, -1, 31'h5555_5555, 0, 0, 0, 0); rows.push_back(r);
		r.p = mk(32'sh5555_5555, 32'shAAAA_AAAA, 31'h2AAA_AAAA, 32'shAAAA_AAAA,
			32'sh5555_5555, 31'h5555_5555, 31'h2AAA_AAAA); rows.push_back(r);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < rows.size(); i++)
			send_pair(rows[i].p, rows[i].typed, rows[i].m);
		for (phase = 0; phase <= LAST_PHASE; phase++)
			for (int i = 0; i < RANDOM_ITEMS / 3; i++)
				send_pair(random_pair(), 1'b0, none);
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// receiver stall: one long hold-off, then random per phase
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_done = 1'b1;
		forever begin
			out_stall <= (phase < LAST_PHASE) && ($urandom_range(0, 99) < (phase == 0 ? 51 : 27));
			@(posedge clk);
		end
	end

	// compare each result transfer against the oldest expectation
	always @(posedge clk) begin
		manifold_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (contact_a_x !== e.ax) begin
					$error("contact_a_x exp %0d got %0d", e.ax, contact_a_x); errors++;
				end
				if (contact_a_y !== e.ay) begin
					$error("contact_a_y exp %0d got %0d", e.ay, contact_a_y); errors++;
				end
				if (contact_b_x !== e.bx) begin
					$error("contact_b_x exp %0d got %0d", e.bx, contact_b_x); errors++;
				end
				if (contact_b_y !== e.by) begin
					$error("contact_b_y exp %0d got %0d", e.by, contact_b_y); errors++;
				end
				if (normal_x !== e.nx) begin
					$error("normal_x exp %0d got %0d", e.nx, normal_x); errors++;
				end
				if (normal_y !== e.ny) begin
					$error("normal_y exp %0d got %0d", e.ny, normal_y); errors++;
				end
				if (penetration !== e.depth) begin
					$error("penetration exp %0d got %0d", e.depth, penetration); errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// drain and report
	initial begin
		wait (sending_done && hold_done && expected_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
